// ===== design/css_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// css_pkg: shared definitions for the cursor sequence store
// Operation codes, cell control codes, transfer payload types and defaults.
// ----------------------------------------------------------------------------
package css_pkg;

	// Default sizes handed to the top level parameters.
	localparam int CAPACITY_DEFAULT    = 64;
	localparam int VALUE_WIDTH_DEFAULT = 64;

	// Fixed field widths of the transfer payloads.
	localparam int FIELD_W = 64;
	localparam int OP_W    = 4;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	// Number of cells merged by one node of the first gather stage.
	localparam int GROUP_SIZE = 8;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_START        = 4'd0;
	localparam logic [OP_W-1:0] OP_END          = 4'd1;
	localparam logic [OP_W-1:0] OP_LAST         = 4'd2;
	localparam logic [OP_W-1:0] OP_ADVANCE      = 4'd3;
	localparam logic [OP_W-1:0] OP_RETREAT      = 4'd4;
	localparam logic [OP_W-1:0] OP_INSERT       = 4'd5;
	localparam logic [OP_W-1:0] OP_ATTACH       = 4'd6;
	localparam logic [OP_W-1:0] OP_REMOVE       = 4'd7;
	localparam logic [OP_W-1:0] OP_FRONT_INSERT = 4'd8;
	localparam logic [OP_W-1:0] OP_BACK_APPEND  = 4'd9;
	localparam logic [OP_W-1:0] OP_FRONT_REMOVE = 4'd10;
	localparam logic [OP_W-1:0] OP_READ         = 4'd11;

	// What every cell does with its entry in one cycle.
	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_REMOVE = 2'd2;

	// Input item payload.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [FIELD_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} css_item_t;

	// Result item payload.
	typedef struct packed {
		logic [FIELD_W-1:0] current_value;
		logic               current_valid;
		logic [COUNT_W-1:0] count;
		logic [FIELD_W-1:0] read_value;
		logic               error;
	} css_result_t;

	// Control broadcast from the controller to every cell.
	typedef struct packed {
		logic [1:0] kind;
		logic       cur_en;
		logic       rd_en;
	} css_cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/css_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// css_stream_if: valid/ready stream channel
// Carries one payload per transfer; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface css_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/cursor_sequence_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_sequence_store: fixed-capacity ordered word store with a cursor
// Each accepted item passes through the cell row, a registered group stage of
// the OR tree that gathers the selected words, and the result register; a new
// item is taken only once the previous result is in the result register.
// Reset clears the cursor, the count and all valid flags; the entries held
// in the cell row are not reset and are only read below the count.
// ----------------------------------------------------------------------------
module cursor_sequence_store #(
	parameter int CAPACITY_ENTRIES = css_pkg::CAPACITY_DEFAULT,
	parameter int VALUE_WIDTH      = css_pkg::VALUE_WIDTH_DEFAULT
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	css_stream_if.sink   item,
	css_stream_if.source result
);
	import css_pkg::*;

	localparam int POS_W  = $clog2(CAPACITY_ENTRIES + 1);
	localparam int GROUPS = (CAPACITY_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

	css_item_t     item_pl;
	css_cell_ctl_t ctl;
	logic [POS_W-1:0]   upd_pos, cursor, count;
	logic [INDEX_W-1:0] rd_pos;
	logic               error, fire, load;
	logic               v1_q, v2_q, res_valid_q;
	css_result_t        res_q;

	logic [VALUE_WIDTH-1:0] word;
	logic [VALUE_WIDTH-1:0] entry_w [CAPACITY_ENTRIES];
	logic [VALUE_WIDTH-1:0] cur_w   [CAPACITY_ENTRIES];
	logic [VALUE_WIDTH-1:0] rd_w    [CAPACITY_ENTRIES];
	logic [VALUE_WIDTH-1:0] grp_cur_c [GROUPS];
	logic [VALUE_WIDTH-1:0] grp_rd_c  [GROUPS];
	logic [VALUE_WIDTH-1:0] grp_cur_s2 [GROUPS];
	logic [VALUE_WIDTH-1:0] grp_rd_s2  [GROUPS];
	logic [VALUE_WIDTH-1:0] cur_all, rd_all;

	// One item in flight at a time; the result register parts the two sides.
	assign item_pl    = item.payload;
	assign item.ready = !v1_q && !v2_q;
	assign fire       = item.valid && item.ready;
	assign word       = item_pl.value[VALUE_WIDTH-1:0];

	css_ctrl #(
		.CAPACITY_ENTRIES (CAPACITY_ENTRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_pl),
		.ctl     (ctl),
		.upd_pos (upd_pos),
		.cursor  (cursor),
		.count   (count),
		.rd_pos  (rd_pos),
		.error   (error)
	);

	// Row of cells, each wired to its two neighbours.
	for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY_ENTRIES - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end
		css_cell #(
			.CAPACITY_ENTRIES (CAPACITY_ENTRIES),
			.VALUE_WIDTH      (VALUE_WIDTH),
			.INDEX            (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.upd_pos  (upd_pos),
			.cur_pos  (cursor),
			.rd_pos   (rd_pos),
			.word     (word),
			.left     (left_w),
			.right    (right_w),
			.entry    (entry_w[i]),
			.cur_word (cur_w[i]),
			.rd_word  (rd_w[i])
		);
	end

	// First gather stage: merge each group of cells.
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_cur_c[g] = '0;
			grp_rd_c[g]  = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < CAPACITY_ENTRIES) begin
					grp_cur_c[g] = grp_cur_c[g] | cur_w[g * GROUP_SIZE + k];
					grp_rd_c[g]  = grp_rd_c[g] | rd_w[g * GROUP_SIZE + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q) begin
			for (int g = 0; g < GROUPS; g++) begin
				grp_cur_s2[g] <= grp_cur_c[g];
				grp_rd_s2[g]  <= grp_rd_c[g];
			end
		end
	end

	// Second gather stage: merge the groups.
	always_comb begin
		cur_all = '0;
		rd_all  = '0;
		for (int g = 0; g < GROUPS; g++) begin
			cur_all = cur_all | grp_cur_s2[g];
			rd_all  = rd_all | grp_rd_s2[g];
		end
	end

	// Stage valid flags and the result register.
	assign load = v2_q && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v1_q <= fire;
			if (v1_q) begin
				v2_q <= 1'b1;
			end else if (load) begin
				v2_q <= 1'b0;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; controller state stays stable until the next transfer.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.current_value <= FIELD_W'(cur_all);
			res_q.current_valid <= ctl.cur_en;
			res_q.count         <= COUNT_W'(count);
			res_q.read_value    <= FIELD_W'(rd_all);
			res_q.error         <= error;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule
`default_nettype wire

// ===== design/css_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// css_cell: one storage cell of the sequence row
// Holds one entry, takes a neighbour's entry when the row shifts and offers
// its entry to the gather tree when its position is selected.
// ----------------------------------------------------------------------------
module css_cell #(
	parameter int CAPACITY_ENTRIES = css_pkg::CAPACITY_DEFAULT,
	parameter int VALUE_WIDTH      = css_pkg::VALUE_WIDTH_DEFAULT,
	parameter int INDEX            = 0
) (
	input  wire logic                                  clk,
	input  wire css_pkg::css_cell_ctl_t                ctl,
	input  wire logic [$clog2(CAPACITY_ENTRIES+1)-1:0] upd_pos,
	input  wire logic [$clog2(CAPACITY_ENTRIES+1)-1:0] cur_pos,
	input  wire logic [css_pkg::INDEX_W-1:0]           rd_pos,
	input  wire logic [VALUE_WIDTH-1:0]                word,
	input  wire logic [VALUE_WIDTH-1:0]                left,
	input  wire logic [VALUE_WIDTH-1:0]                right,
	output logic      [VALUE_WIDTH-1:0]                entry,
	output logic      [VALUE_WIDTH-1:0]                cur_word,
	output logic      [VALUE_WIDTH-1:0]                rd_word
);
	import css_pkg::*;

	localparam int POS_W = $clog2(CAPACITY_ENTRIES + 1);
	localparam logic [POS_W-1:0]   HERE      = POS_W'(INDEX);
	localparam logic [INDEX_W-1:0] HERE_IDX  = INDEX_W'(INDEX);
	localparam bit                 IDX_REACH = INDEX < (1 << INDEX_W);

	logic [VALUE_WIDTH-1:0] entry_q;

	// Entry update: open a gap, close a gap or hold.
	always_ff @(posedge clk) begin
		case (ctl.kind)
			CELL_INSERT: begin
				if (HERE > upd_pos) begin
					entry_q <= left;
				end else if (HERE == upd_pos) begin
					entry_q <= word;
				end
			end
			CELL_REMOVE: begin
				if (HERE >= upd_pos) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;

	// Gated contributions to the gather tree; unselected cells give zero.
	assign cur_word = (ctl.cur_en && (cur_pos == HERE)) ? entry_q : '0;
	assign rd_word  = (ctl.rd_en && IDX_REACH && (rd_pos == HERE_IDX)) ? entry_q : '0;

endmodule
`default_nettype wire

// ===== design/css_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// css_ctrl: cursor and count controller
// Decodes each accepted item, checks its precondition, drives the cell row
// and keeps the cursor, the count and the status of the last operation.
// ----------------------------------------------------------------------------
module css_ctrl #(
	parameter int CAPACITY_ENTRIES = css_pkg::CAPACITY_DEFAULT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  fire,
	input  wire css_pkg::css_item_t                    item,
	output css_pkg::css_cell_ctl_t                     ctl,
	output logic      [$clog2(CAPACITY_ENTRIES+1)-1:0] upd_pos,
	output logic      [$clog2(CAPACITY_ENTRIES+1)-1:0] cursor,
	output logic      [$clog2(CAPACITY_ENTRIES+1)-1:0] count,
	output logic      [css_pkg::INDEX_W-1:0]           rd_pos,
	output logic                                       error
);
	import css_pkg::*;

	localparam int POS_W = $clog2(CAPACITY_ENTRIES + 1);
	localparam int IW    = (POS_W > INDEX_W) ? POS_W : INDEX_W;
	localparam logic [POS_W-1:0] CAP_POS  = POS_W'(CAPACITY_ENTRIES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(CAPACITY_ENTRIES - 1);

	logic [POS_W-1:0]   cursor_q, count_q;
	logic [INDEX_W-1:0] rd_pos_q;
	logic               error_q, rd_en_q;

	logic [POS_W-1:0] cursor_n, count_n, pos_n;
	logic [1:0]       kind_n;
	logic             error_n, rd_en_n, has_cur, full;

	// Operation decode and precondition checks.
	always_comb begin
		cursor_n = cursor_q;
		count_n  = count_q;
		pos_n    = '0;
		kind_n   = CELL_HOLD;
		error_n  = 1'b0;
		rd_en_n  = 1'b0;
		has_cur  = cursor_q < count_q;
		full     = count_q == CAP_POS;
		case (item.op)
			OP_START: begin
				cursor_n = '0;
			end
			OP_END: begin
				cursor_n = count_q;
			end
			OP_LAST: begin
				cursor_n = LAST_POS;
			end
			OP_ADVANCE: begin
				if (has_cur) cursor_n = cursor_q + 1'b1;
				else error_n = 1'b1;
			end
			OP_RETREAT: begin
				if (cursor_q != '0) cursor_n = cursor_q - 1'b1;
				else error_n = 1'b1;
			end
			OP_INSERT: begin
				if (full) begin
					error_n = 1'b1;
				end else begin
					pos_n    = has_cur ? cursor_q : '0;
					cursor_n = pos_n;
					count_n  = count_q + 1'b1;
					kind_n   = CELL_INSERT;
				end
			end
			OP_ATTACH: begin
				if (full) begin
					error_n = 1'b1;
				end else begin
					pos_n    = has_cur ? cursor_q + 1'b1 : count_q;
					cursor_n = pos_n;
					count_n  = count_q + 1'b1;
					kind_n   = CELL_INSERT;
				end
			end
			OP_REMOVE: begin
				if (has_cur) begin
					pos_n   = cursor_q;
					count_n = count_q - 1'b1;
					kind_n  = CELL_REMOVE;
				end else begin
					error_n = 1'b1;
				end
			end
			OP_FRONT_INSERT: begin
				if (full) begin
					error_n = 1'b1;
				end else begin
					pos_n    = '0;
					cursor_n = '0;
					count_n  = count_q + 1'b1;
					kind_n   = CELL_INSERT;
				end
			end
			OP_BACK_APPEND: begin
				if (full) begin
					error_n = 1'b1;
				end else begin
					pos_n    = count_q;
					cursor_n = count_q;
					count_n  = count_q + 1'b1;
					kind_n   = CELL_INSERT;
				end
			end
			OP_FRONT_REMOVE: begin
				if (has_cur) begin
					pos_n    = '0;
					cursor_n = '0;
					count_n  = count_q - 1'b1;
					kind_n   = CELL_REMOVE;
				end else begin
					error_n = 1'b1;
				end
			end
			OP_READ: begin
				if (IW'(item.index) < IW'(count_q)) rd_en_n = 1'b1;
				else error_n = 1'b1;
			end
			default: begin
				error_n = 1'b1;
			end
		endcase
	end

	// State update on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			count_q  <= '0;
			error_q  <= 1'b0;
			rd_en_q  <= 1'b0;
		end else if (fire) begin
			cursor_q <= cursor_n;
			count_q  <= count_n;
			error_q  <= error_n;
			rd_en_q  <= rd_en_n;
		end
	end

	// Read position is payload only.
	always_ff @(posedge clk) begin
		if (fire) rd_pos_q <= item.index;
	end

	// Row control: shifts act at the transfer edge, selects use stored state.
	assign ctl.kind   = fire ? kind_n : CELL_HOLD;
	assign ctl.cur_en = cursor_q < count_q;
	assign ctl.rd_en  = rd_en_q;
	assign upd_pos    = pos_n;
	assign cursor     = cursor_q;
	assign count      = count_q;
	assign rd_pos     = rd_pos_q;
	assign error      = error_q;

endmodule
`default_nettype wire

// ===== tb/cursor_sequence_store_tb.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_store_tb: self-checking bench for the cursor sequence store
// A table of directed items walks the corner cases of the cursor and of the
// store. It is followed by random items in growing, mixed and draining
// phases. Every accepted item is run through a local model of the store, and
// each result transfer is compared field by field with the oldest prediction.
// Both sides of the block idle at random, and the receiver holds off once for
// a long stretch.
// ----------------------------------------------------------------------------
module cursor_sequence_store_tb;
	import css_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEFAULT;
	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES  = 200;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PCT     = 34;

	// Operation codes that the block does not define.
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd12;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

	// One row of the directed table; the typed result applies when known is set.
	typedef struct {
		logic [OP_W-1:0]    op;
		logic [FIELD_W-1:0] value;
		logic [INDEX_W-1:0] index;
		bit                 known;
		logic [FIELD_W-1:0] cur_value;
		bit                 cur_valid;
		logic [COUNT_W-1:0] count;
		logic [FIELD_W-1:0] read_value;
		bit                 error;
	} directed_row_t;

	logic clk;
	logic arst_n;

	css_stream_if #(.payload_t(css_item_t))   item_ch ();
	css_stream_if #(.payload_t(css_result_t)) result_ch ();

	cursor_sequence_store DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Local copy of the store, its count and its cursor.
	logic [FIELD_W-1:0] store_words [CAPACITY];
	int unsigned        fill    = 0;
	int unsigned        cur_pos = 0;

	css_result_t expected_results [$];
	int unsigned fail_count    = 0;
	int unsigned idle_pct      = IDLE_PCT;
	bit          hold_off_req  = 1'b0;

	// The store starts empty, so every early row can be read off directly.
	directed_row_t directed_rows [25] = '{
		'{OP_START,        64'h0, 6'd0,  1, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_ADVANCE,      64'h0, 6'd0,  1, 64'h0, 0, 7'd0, 64'h0, 1},
		'{OP_RETREAT,      64'h0, 6'd0,  1, 64'h0, 0, 7'd0, 64'h0, 1},
		'{OP_REMOVE,       64'h0, 6'd0,  1, 64'h0, 0, 7'd0, 64'h0, 1},
		'{OP_FRONT_REMOVE, 64'h0, 6'd0,  1, 64'h0, 0, 7'd0, 64'h0, 1},
		'{OP_READ,         64'h0, 6'd0,  1, 64'h0, 0, 7'd0, 64'h0, 1},
		'{OP_UNUSED_LO,    64'h0, 6'd0,  1, 64'h0, 0, 7'd0, 64'h0, 1},
		'{OP_UNUSED_HI,    64'h0, 6'd63, 1, 64'h0, 0, 7'd0, 64'h0, 1},
		'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0,
			1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 7'd1, 64'h0, 0},
		'{OP_ATTACH,       64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_END,          64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_ATTACH, 64'hA5A5_5A5A_0F0F_F0F0, 6'd0, 0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_FRONT_INSERT, 64'h1, 6'd0, 0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_BACK_APPEND, 64'h8000_0000_0000_0000, 6'd0,
			0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_LAST,         64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_ADVANCE,      64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_START,        64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_ADVANCE,      64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_RETREAT,      64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_INSERT, 64'h0123_4567_89AB_CDEF, 6'd0, 0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_READ,         64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_READ,         64'h0, 6'd63, 0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_REMOVE,       64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_FRONT_REMOVE, 64'h0, 6'd0,  0, 64'h0, 0, 7'd0, 64'h0, 0},
		'{OP_READ,         64'h0, 6'd1,  0, 64'h0, 0, 7'd0, 64'h0, 0}
	};

	// Open a gap at pos, shifting every later word up by one, and fill it.
	function automatic void open_slot(int unsigned pos, logic [FIELD_W-1:0] word);
		for (int unsigned i = fill; i > pos; i--) begin
			store_words[i] = store_words[i-1];
		end
		store_words[pos] = word;
		fill++;
	endfunction

	// Close the gap at pos, shifting every later word down by one.
	function automatic void close_slot(int unsigned pos);
		for (int unsigned i = pos; i + 1 < fill; i++) begin
			store_words[i] = store_words[i+1];
		end
		fill--;
	endfunction

	// Apply one item to the local store and return the result it should give.
	function automatic css_result_t store_step(css_item_t it);
		css_result_t r;
		bit          is_full;
		bit          has_cur;
		r       = '0;
		is_full = (fill >= CAPACITY);
		has_cur = (cur_pos < fill);
		case (it.op)
			OP_START: cur_pos = 0;
			OP_END:   cur_pos = fill;
			OP_LAST:  cur_pos = CAPACITY - 1;
			OP_ADVANCE: begin
				if (has_cur) cur_pos++;
				else r.error = 1'b1;
			end
			OP_RETREAT: begin
				if (cur_pos > 0) cur_pos--;
				else r.error = 1'b1;
			end
			OP_INSERT: begin
				if (is_full) begin
					r.error = 1'b1;
				end else begin
					if (!has_cur) cur_pos = 0;
					open_slot(cur_pos, it.value);
				end
			end
			OP_ATTACH: begin
				if (is_full) begin
					r.error = 1'b1;
				end else begin
					if (!has_cur) cur_pos = fill;
					else cur_pos++;
					open_slot(cur_pos, it.value);
				end
			end
			OP_REMOVE: begin
				if (has_cur) close_slot(cur_pos);
				else r.error = 1'b1;
			end
			OP_FRONT_INSERT: begin
				if (is_full) begin
					r.error = 1'b1;
				end else begin
					cur_pos = 0;
					open_slot(0, it.value);
				end
			end
			OP_BACK_APPEND: begin
				if (is_full) begin
					r.error = 1'b1;
				end else begin
					cur_pos = fill;
					open_slot(cur_pos, it.value);
				end
			end
			OP_FRONT_REMOVE: begin
				if (has_cur) begin
					close_slot(0);
					cur_pos = 0;
				end else begin
					r.error = 1'b1;
				end
			end
			OP_READ: begin
				if (it.index < fill) r.read_value = store_words[it.index];
				else r.error = 1'b1;
			end
			default: r.error = 1'b1;
		endcase
		r.current_valid = (cur_pos < fill);
		r.current_value = r.current_valid ? store_words[cur_pos] : '0;
		r.count         = COUNT_W'(fill);
		return r;
	endfunction

	// Random item: phases that grow the store to full, mix all operations,
	// and drain it again.
	function automatic css_item_t random_item(int unsigned n);
		css_item_t   it;
		int unsigned phase;
		int unsigned pick;
		phase = n % 200;
		pick  = $urandom_range(99);
		it.op = OP_W'($urandom_range(15));
		if (phase < 110 && pick < 75) begin
			case ($urandom_range(3))
				0:       it.op = OP_INSERT;
				1:       it.op = OP_ATTACH;
				2:       it.op = OP_FRONT_INSERT;
				default: it.op = OP_BACK_APPEND;
			endcase
		end else if (phase >= 150 && pick < 50) begin
			it.op = pick[0] ? OP_REMOVE : OP_FRONT_REMOVE;
		end else if (phase >= 150 && pick < 70) begin
			it.op = OP_START;
		end else if (pick >= 88) begin
			it.op = OP_READ;
		end
		case ($urandom_range(7))
			0:       it.value = '0;
			1:       it.value = '1;
			2:       it.value = 64'd1 << $urandom_range(63);
			default: it.value = {$urandom, $urandom};
		endcase
		it.index = INDEX_W'($urandom);
		if (it.op == OP_READ && fill != 0 && $urandom_range(9) < 7) begin
			it.index = INDEX_W'($urandom_range(fill - 1));
		end
		return it;
	endfunction

	// Offer one item until it is taken, then record the result it should give.
	task automatic offer_item(input css_item_t it, input bit known,
			input css_result_t typed_result);
		css_result_t want;
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.payload = it;
		item_ch.valid   = 1'b1;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		want = store_step(it);
		if (known) want = typed_result;
		expected_results.push_back(want);
		@(negedge clk);
	endtask

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Reset is asserted from the start and released at a falling edge.
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			result_ch.ready = arst_n && ($urandom_range(99) >= idle_pct);
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		css_result_t want;
		css_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			if (expected_results.size() == 0) begin
				$error("result transfer with no prediction waiting");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.current_value !== want.current_value) begin
					$error("current_value expected %h actual %h",
						want.current_value, got.current_value);
					fail_count++;
				end
				if (got.current_valid !== want.current_valid) begin
					$error("current_valid expected %b actual %b",
						want.current_valid, got.current_valid);
					fail_count++;
				end
				if (got.count !== want.count) begin
					$error("count expected %0d actual %0d", want.count, got.count);
					fail_count++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value expected %h actual %h",
						want.read_value, got.read_value);
					fail_count++;
				end
				if (got.error !== want.error) begin
					$error("error expected %b actual %b", want.error, got.error);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("[cursor_sequence_store] ERROR");
		$finish;
	end

	// Stimulus: the directed table, then the random phases.
	initial begin
		css_item_t   row_item;
		css_result_t row_result;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row_item.op              = directed_rows[i].op;
			row_item.value           = directed_rows[i].value;
			row_item.index           = directed_rows[i].index;
			row_result.current_value = directed_rows[i].cur_value;
			row_result.current_valid = directed_rows[i].cur_valid;
			row_result.count         = directed_rows[i].count;
			row_result.read_value    = directed_rows[i].read_value;
			row_result.error         = directed_rows[i].error;
			offer_item(row_item, directed_rows[i].known, row_result);
		end

		// A stretch of the random part runs with no idling on either side.
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			idle_pct = (n >= 200 && n < 300) ? 0 : IDLE_PCT;
			if (n == 350) hold_off_req = 1'b1;
			offer_item(random_item(n), 1'b0, '0);
		end
		item_ch.valid = 1'b0;

		// Drain the outstanding results, then allow for any stray transfer.
		while (expected_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("[cursor_sequence_store] OK");
		end else begin
			$display("[cursor_sequence_store] ERROR");
		end
		$finish;
	end

endmodule
